// ===== hw/rtl/asl_pkg.sv =====
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants of the assembler source lexer
// Byte classes, lexer states, token kinds, error codes and the records
// passed between the front, the item queue and the back.
// ----------------------------------------------------------------------------
package asl_pkg;

	// Offset counter width and its largest value
	localparam int OFF_BITS = 16;
	localparam logic [OFF_BITS-1:0] OFF_MAX = '1;

	// Width of token_start / token_length and their saturation value
	localparam int TOK_W = 16;
	localparam logic [TOK_W-1:0] TOK_MAX = '1;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Result buffer in the back: one byte gives at most this many tokens
	localparam int RES_SLOTS = 3;
	localparam int RES_CNT_W = 2;

	// Byte classes decided by the front
	typedef enum logic [3:0] {
		CL_SPACE,
		CL_NEWLINE,
		CL_ALPHA,
		CL_DIGIT,
		CL_UNDER,
		CL_MINUS,
		CL_POINT,
		CL_HASH,
		CL_DOLLAR,
		CL_SQUOTE,
		CL_DQUOTE,
		CL_BSLASH,
		CL_OTHER
	} cls_t;

	// Lexer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORD,
		ST_NUM,
		ST_COMMENT,
		ST_SLOT,
		ST_CHAR1,
		ST_CHAR2,
		ST_STRING
	} lex_state_t;

	// Token kinds
	typedef enum logic [3:0] {
		K_WORD,
		K_INT,
		K_FLOAT,
		K_CHAR,
		K_STRING,
		K_SYMBOL,
		K_SLOT,
		K_END,
		K_ERROR
	} kind_t;

	// Error codes
	typedef enum logic [2:0] {
		E_NONE,
		E_POINT,
		E_NUM_LETTER,
		E_CHAR,
		E_STRING,
		E_SLOT_LETTER,
		E_SLOT_EMPTY,
		E_OVERFLOW
	} err_t;

	// Classified byte, front to back
	typedef struct packed {
		cls_t cls;
		logic fin;
	} item_t;

	// One token result
	typedef struct packed {
		kind_t            kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] len;
		err_t             code;
		logic             last;
	} res_t;

endpackage

// ===== hw/rtl/assembler_source_lexer.sv =====
// ----------------------------------------------------------------------------
// assembler_source_lexer: streaming lexer for assembler source text
// Bytes in, tokens out as kind, start offset and length; errors carry a
// code and halt the lexer until the final byte.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake        payload
//  -------   ---------  ---------------  ------------------------------------
//  source    in         push / full      source_byte, is_final
//  tokens    out        empty / pop      token_kind, token_start,
//                                        token_length, error_code, run_last
//
//  One byte per cycle while each byte gives at most one token and pop keeps
//  up; a byte that gives several tokens holds the back until its last token
//  goes out, since the result buffer hands out one token per transfer.
//  The first token of a byte is registered in the queue, then in the result buffer.
//  A four-entry queue lets bytes flow in while the back waits on pop.
//  Reset is asynchronous: queue empty, lexer idle at offset zero.
// ----------------------------------------------------------------------------
module assembler_source_lexer import asl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       source_byte,
	input  logic             is_final,
	output logic             empty,
	input  logic             pop,
	output logic [3:0]       token_kind,
	output logic [TOK_W-1:0] token_start,
	output logic [TOK_W-1:0] token_length,
	output logic [2:0]       error_code,
	output logic             run_last
);

	logic  wr_en, rd_en, rd_valid, q_full;
	item_t wr_item, rd_item;
	res_t  head;

	asl_front u_front (
		.push        (push),
		.source_byte (source_byte),
		.is_final    (is_final),
		.q_full      (q_full),
		.wr_en       (wr_en),
		.wr_item     (wr_item)
	);

	asl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_item  (wr_item),
		.full     (q_full),
		.rd_en    (rd_en),
		.rd_valid (rd_valid),
		.rd_item  (rd_item)
	);

	asl_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid),
		.in_item  (rd_item),
		.in_take  (rd_en),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	assign full         = q_full;
	assign token_kind   = head.kind;
	assign token_start  = head.start;
	assign token_length = head.len;
	assign error_code   = head.code;
	assign run_last     = head.last;

endmodule

// ===== hw/rtl/asl_front.sv =====
// ----------------------------------------------------------------------------
// asl_front: input side of the lexer
// Takes source bytes, sorts each into a byte class and writes the class
// with the final flag into the item queue.
// ----------------------------------------------------------------------------
module asl_front import asl_pkg::*; (
	input  logic       push,
	input  logic [7:0] source_byte,
	input  logic       is_final,
	input  logic       q_full,
	output logic       wr_en,
	output item_t      wr_item
);

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_POINT  = 8'h2e;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_UNDER  = 8'h5f;

	cls_t cls;

	// Byte classification; only ASCII letters count as letters
	always_comb begin
		case (source_byte) inside
			CH_SPACE, CH_TAB:             cls = CL_SPACE;
			CH_NL:                        cls = CL_NEWLINE;
			[8'h41:8'h5a], [8'h61:8'h7a]: cls = CL_ALPHA;
			[8'h30:8'h39]:                cls = CL_DIGIT;
			CH_UNDER:                     cls = CL_UNDER;
			CH_MINUS:                     cls = CL_MINUS;
			CH_POINT:                     cls = CL_POINT;
			CH_HASH:                      cls = CL_HASH;
			CH_DOLLAR:                    cls = CL_DOLLAR;
			CH_SQUOTE:                    cls = CL_SQUOTE;
			CH_DQUOTE:                    cls = CL_DQUOTE;
			CH_BSLASH:                    cls = CL_BSLASH;
			default:                      cls = CL_OTHER;
		endcase
	end

	// Transfer into the queue
	assign wr_en       = push && !q_full;
	assign wr_item.cls = cls;
	assign wr_item.fin = is_final;

endmodule

// ===== hw/rtl/asl_queue.sv =====
// ----------------------------------------------------------------------------
// asl_queue: item queue between front and back
// Small first-in first-out store of classified bytes so that the input
// keeps flowing while the back drains a multi-token byte.
// ----------------------------------------------------------------------------
module asl_queue import asl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd_en,
	output logic  rd_valid,
	output item_t rd_item
);

	item_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign full     = cnt_q == (QPTR_W+1)'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item  = mem_q[rd_q];

endmodule

// ===== hw/rtl/asl_back.sv =====
// ----------------------------------------------------------------------------
// asl_back: lexer state machine and result buffer
// Runs one lexer step per classified byte, collects the up to three tokens
// the step gives and hands them out one per transfer.
// ----------------------------------------------------------------------------
module asl_back import asl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  item_t in_item,
	output logic  in_take,
	input  logic  pop,
	output logic  empty,
	output res_t  head
);

	localparam int NCAND = 5;
	localparam logic [OFF_BITS:0] ONE = (OFF_BITS+1)'(1);

	// Clamp a wide offset or length to the port width
	function automatic logic [TOK_W-1:0] sat(logic [OFF_BITS:0] v);
		logic [TOK_W-1:0] r;
		r = (33'(v) > 33'(TOK_MAX)) ? TOK_MAX : TOK_W'(v);
		return r;
	endfunction

	function automatic res_t mk(kind_t k, logic [OFF_BITS:0] s, logic [OFF_BITS:0] l,
			err_t e);
		res_t r;
		r.kind  = k;
		r.start = sat(s);
		r.len   = sat(l);
		r.code  = e;
		r.last  = 1'b0;
		return r;
	endfunction

	// Lexer state
	lex_state_t          st_q;
	logic [OFF_BITS-1:0] off_q;
	logic [OFF_BITS:0]   beg_q;
	logic                sp_q;
	logic                mp_q;
	logic                ep_q;
	logic                halt_q;

	// Result buffer
	res_t                 buf_q [RES_SLOTS];
	logic [RES_CNT_W-1:0] n_q;

	// Step signals
	logic              take, pop_acc, load_ok, fin;
	logic              is_al, is_dg, is_un, is_pt;
	logic [OFF_BITS:0] p17, p1, ecl;
	logic              at_max;
	logic              rs, lex_err;
	logic              a_v, b_v, c_v, d_v, e_v;
	res_t              a, b, c, d, e;
	lex_state_t        lx_st, st_d;
	logic [OFF_BITS:0] lx_beg, beg_d;
	logic              lx_sp, lx_mp, lx_ep, sp_d, mp_d, ep_d, halt_d;
	logic [OFF_BITS-1:0] off_d;
	res_t              cand [NCAND];
	logic [NCAND-1:0]  cv;
	res_t              slot [RES_SLOTS];
	logic [RES_CNT_W-1:0] n_new;

	assign fin    = in_item.fin;
	assign is_al  = in_item.cls == CL_ALPHA;
	assign is_dg  = in_item.cls == CL_DIGIT;
	assign is_un  = in_item.cls == CL_UNDER;
	assign is_pt  = in_item.cls == CL_POINT;
	assign p17    = {1'b0, off_q};
	assign p1     = p17 + ONE;
	assign ecl    = p1[OFF_BITS] ? p17 : p1;
	assign at_max = off_q == OFF_MAX;

	// Handshake: load a new step when the buffer is empty or giving its last
	assign pop_acc = pop && n_q != '0;
	assign load_ok = n_q == '0 || (n_q == RES_CNT_W'(1) && pop_acc);
	assign take    = in_valid && load_ok;
	assign in_take = take;

	// Lexer outputs of the current byte: closing token or error, then a symbol
	always_comb begin
		a_v = 1'b0;
		a   = mk(K_WORD, '0, '0, E_NONE);
		rs  = 1'b0;
		case (st_q)
			ST_WORD: begin
				if (!(is_al || is_dg || is_un)) begin
					a_v = 1'b1;
					a   = mk(K_WORD, beg_q, p17 - beg_q, E_NONE);
					rs  = 1'b1;
				end
			end
			ST_NUM: begin
				if (mp_q) begin
					if (!is_dg) begin
						a_v = 1'b1;
						a   = mk(K_SYMBOL, beg_q, ONE, E_NONE);
						rs  = 1'b1;
					end
				end else if (is_dg) begin
					a_v = 1'b0;
				end else if (is_pt) begin
					a_v = sp_q;
					a   = mk(K_ERROR, p17, '0, E_POINT);
				end else if (is_al) begin
					a_v = 1'b1;
					a   = mk(K_ERROR, p17, '0, E_NUM_LETTER);
				end else begin
					a_v = 1'b1;
					a   = mk(sp_q ? K_FLOAT : K_INT, beg_q, p17 - beg_q, E_NONE);
					rs  = 1'b1;
				end
			end
			ST_COMMENT: begin
				a_v = 1'b0;
			end
			ST_SLOT: begin
				if (is_dg) begin
					a_v = 1'b0;
				end else if (is_al) begin
					a_v = 1'b1;
					a   = mk(K_ERROR, p17, '0, E_SLOT_LETTER);
				end else if (p17 == beg_q) begin
					a_v = 1'b1;
					a   = mk(K_ERROR, p17, '0, E_SLOT_EMPTY);
				end else begin
					a_v = 1'b1;
					a   = mk(K_SLOT, beg_q, p17 - beg_q, E_NONE);
					rs  = 1'b1;
				end
			end
			ST_CHAR1: begin
				a_v = 1'b0;
			end
			ST_CHAR2: begin
				a_v = 1'b1;
				if (in_item.cls == CL_SQUOTE) begin
					a = mk(K_CHAR, beg_q, ONE, E_NONE);
				end else begin
					a = mk(K_ERROR, p17, '0, E_CHAR);
				end
			end
			ST_STRING: begin
				if (!ep_q && in_item.cls == CL_DQUOTE) begin
					a_v = 1'b1;
					a   = mk(K_STRING, beg_q, p17 - beg_q, E_NONE);
				end
			end
			default: begin
				rs = 1'b1;
			end
		endcase
		lex_err = a_v && a.kind == K_ERROR;
		// A point, backslash or other byte that opens no token is a one-byte symbol
		b_v = rs && (in_item.cls == CL_OTHER || is_pt || in_item.cls == CL_BSLASH);
		b   = mk(K_SYMBOL, p17, ONE, E_NONE);
	end

	// Lexer next state for the current byte
	always_comb begin
		lx_st  = st_q;
		lx_beg = beg_q;
		lx_sp  = sp_q;
		lx_mp  = mp_q;
		lx_ep  = ep_q;
		case (st_q)
			ST_NUM: begin
				if (mp_q) begin
					lx_mp = 1'b0;
				end else if (!is_dg && is_pt) begin
					lx_sp = 1'b1;
				end
			end
			ST_COMMENT: begin
				if (in_item.cls == CL_NEWLINE) begin
					lx_st = ST_IDLE;
				end
			end
			ST_CHAR1: begin
				lx_st = ST_CHAR2;
			end
			ST_CHAR2: begin
				lx_st = ST_IDLE;
			end
			ST_STRING: begin
				if (ep_q) begin
					lx_ep = 1'b0;
				end else if (in_item.cls == CL_BSLASH) begin
					lx_ep = 1'b1;
				end else if (in_item.cls == CL_DQUOTE) begin
					lx_st = ST_IDLE;
				end
			end
			default: begin
				lx_st = st_q;
			end
		endcase
		// Open a new token after closing the old one
		if (rs) begin
			lx_st = ST_IDLE;
			case (in_item.cls)
				CL_ALPHA, CL_UNDER: begin
					lx_st  = ST_WORD;
					lx_beg = p17;
				end
				CL_DIGIT, CL_MINUS: begin
					lx_st  = ST_NUM;
					lx_beg = p17;
					lx_sp  = 1'b0;
					lx_mp  = in_item.cls == CL_MINUS;
				end
				CL_HASH: begin
					lx_st = ST_COMMENT;
				end
				CL_DOLLAR: begin
					lx_st  = ST_SLOT;
					lx_beg = p1;
				end
				CL_SQUOTE: begin
					lx_st  = ST_CHAR1;
					lx_beg = p1;
				end
				CL_DQUOTE: begin
					lx_st  = ST_STRING;
					lx_beg = p1;
					lx_ep  = 1'b0;
				end
				default: begin
					lx_st = ST_IDLE;
				end
			endcase
		end
	end

	// End of input flush and offset overflow outputs
	always_comb begin
		c_v = 1'b0;
		c   = mk(K_END, '0, '0, E_NONE);
		d_v = 1'b0;
		d   = mk(K_END, '0, '0, E_NONE);
		e_v = 1'b0;
		e   = mk(K_ERROR, p17, '0, E_OVERFLOW);
		if (fin && !lex_err) begin
			case (lx_st)
				ST_WORD: begin
					c_v = 1'b1;
					c   = mk(K_WORD, lx_beg, p1 - lx_beg, E_NONE);
				end
				ST_NUM: begin
					c_v = 1'b1;
					if (lx_mp) begin
						c = mk(K_SYMBOL, lx_beg, ONE, E_NONE);
					end else begin
						c = mk(lx_sp ? K_FLOAT : K_INT, lx_beg, p1 - lx_beg, E_NONE);
					end
				end
				ST_SLOT: begin
					c_v = 1'b1;
					if (p1 == lx_beg) begin
						c = mk(K_ERROR, ecl, '0, E_SLOT_EMPTY);
					end else begin
						c = mk(K_SLOT, lx_beg, p1 - lx_beg, E_NONE);
					end
				end
				ST_CHAR1, ST_CHAR2: begin
					c_v = 1'b1;
					c   = mk(K_ERROR, ecl, '0, E_CHAR);
				end
				ST_STRING: begin
					c_v = 1'b1;
					c   = mk(K_ERROR, ecl, '0, E_STRING);
				end
				default: begin
					c_v = 1'b0;
				end
			endcase
			d_v = !(c_v && c.kind == K_ERROR);
		end else if (!fin && !lex_err && at_max) begin
			e_v = 1'b1;
		end
	end

	// Pack the valid results in order and mark the last one
	always_comb begin
		cand[0] = a;
		cand[1] = b;
		cand[2] = c;
		cand[3] = d;
		cand[4] = e;
		cv      = halt_q ? '0 : {e_v, d_v, c_v, b_v, a_v};
		for (int s = 0; s < RES_SLOTS; s++) begin
			slot[s] = a;
		end
		n_new = '0;
		for (int i = 0; i < NCAND; i++) begin
			if (cv[i] && n_new != RES_CNT_W'(RES_SLOTS)) begin
				slot[n_new] = cand[i];
				n_new       = n_new + RES_CNT_W'(1);
			end
		end
		if (n_new != '0) begin
			slot[n_new - RES_CNT_W'(1)].last = 1'b1;
		end
	end

	// State after the step: final byte clears, a halted lexer holds
	always_comb begin
		st_d   = lx_st;
		beg_d  = lx_beg;
		sp_d   = lx_sp;
		mp_d   = lx_mp;
		ep_d   = lx_ep;
		halt_d = lex_err || at_max;
		off_d  = (lex_err || at_max) ? off_q : off_q + OFF_BITS'(1);
		if (fin) begin
			st_d   = ST_IDLE;
			beg_d  = '0;
			sp_d   = 1'b0;
			mp_d   = 1'b0;
			ep_d   = 1'b0;
			halt_d = 1'b0;
			off_d  = '0;
		end else if (halt_q) begin
			st_d   = st_q;
			beg_d  = beg_q;
			sp_d   = sp_q;
			mp_d   = mp_q;
			ep_d   = ep_q;
			halt_d = halt_q;
			off_d  = off_q;
		end
	end

	// Lexer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			off_q  <= '0;
			beg_q  <= '0;
			sp_q   <= 1'b0;
			mp_q   <= 1'b0;
			ep_q   <= 1'b0;
			halt_q <= 1'b0;
		end else if (take) begin
			st_q   <= st_d;
			off_q  <= off_d;
			beg_q  <= beg_d;
			sp_q   <= sp_d;
			mp_q   <= mp_d;
			ep_q   <= ep_d;
			halt_q <= halt_d;
		end
	end

	// Result buffer count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (take) begin
			n_q <= n_new;
		end else if (pop_acc) begin
			n_q <= n_q - RES_CNT_W'(1);
		end
	end

	// Result buffer payload: load a whole step or shift out the head
	always_ff @(posedge clk) begin
		if (take) begin
			for (int s = 0; s < RES_SLOTS; s++) begin
				buf_q[s] <= slot[s];
			end
		end else if (pop_acc) begin
			for (int s = 0; s < RES_SLOTS - 1; s++) begin
				buf_q[s] <= buf_q[s+1];
			end
		end
	end

	assign empty = n_q == '0;
	assign head  = buf_q[0];

	// Checks
	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		take && fin |=> st_q == ST_IDLE && off_q == '0 && !halt_q)
		else $error("final byte did not return the lexer to idle");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && halt_q |-> n_new == '0)
		else $error("halted lexer produced a result");

	a_off_step: assert property (@(posedge clk) disable iff (!arst_n)
		take && !fin && !halt_q && !lex_err && !at_max |=>
		off_q == $past(off_q) + OFF_BITS'(1))
		else $error("offset did not advance by one");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> buf_q[n_q - RES_CNT_W'(1)].last)
		else $error("newest buffered result lacks its last mark");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop_acc && !take |=> n_q == $past(n_q) - RES_CNT_W'(1))
		else $error("result count did not drop on transfer");

endmodule
